/* src/rdpneg_pkg.sv */
// ----------------------------------------------------------------------------
// rdpneg_pkg
// Types and constants for the TPKT / COTP / RDP negotiation reply parser.
// ----------------------------------------------------------------------------
package rdpneg_pkg;

	typedef struct packed {
		logic       starts_stream;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic [31:0] negotiation_result;
		logic [7:0]  negotiation_flags;
	} out_word_t;

	// One event from the parser core; at most one per accepted byte.
	typedef struct packed {
		logic      valid;
		out_word_t word;
	} evt_t;

	typedef enum logic [2:0] {
		EV_NLA_SUPPORTED   = 3'd0,
		EV_NLA_UNUSED      = 3'd1,
		EV_NLA_UNSUPPORTED = 3'd2,
		EV_FAILURE         = 3'd3,
		EV_UNKNOWN_COTP    = 3'd4,
		EV_NOT_TPKT        = 3'd5,
		EV_BAD_COTP_LEN    = 3'd6,
		EV_BAD_NEG_LEN     = 3'd7
	} evt_code_t;

	typedef enum logic [5:0] {
		TP_VERSION  = 6'b000001,
		TP_RESERVED = 6'b000010,
		TP_LEN_HI   = 6'b000100,
		TP_LEN_LO   = 6'b001000,
		TP_CONTENT  = 6'b010000,
		TP_DEAD     = 6'b100000
	} tp_state_t;

	typedef enum logic [8:0] {
		CO_LENGTH  = 9'b000000001,
		CO_TYPE    = 9'b000000010,
		CO_REF0    = 9'b000000100,
		CO_REF1    = 9'b000001000,
		CO_REF2    = 9'b000010000,
		CO_REF3    = 9'b000100000,
		CO_CLASS   = 9'b001000000,
		CO_CONTENT = 9'b010000000,
		CO_DONE    = 9'b100000000
	} co_state_t;

	typedef enum logic [8:0] {
		NG_TYPE     = 9'b000000001,
		NG_FLAGS    = 9'b000000010,
		NG_LENGTH   = 9'b000000100,
		NG_RESERVED = 9'b000001000,
		NG_RESULT0  = 9'b000010000,
		NG_RESULT1  = 9'b000100000,
		NG_RESULT2  = 9'b001000000,
		NG_RESULT3  = 9'b010000000,
		NG_DONE     = 9'b100000000
	} ng_state_t;

	localparam logic [7:0]  TPKT_VERSION         = 8'd3;
	localparam logic [15:0] TPKT_HDR_LEN         = 16'd4;
	localparam logic [7:0]  COTP_MIN_LEN         = 8'd6;
	localparam logic [7:0]  COTP_CC_PDU          = 8'hd0;
	localparam logic [7:0]  NEG_MIN_LEN          = 8'd4;
	localparam logic [7:0]  NEG_TYPE_RESPONSE    = 8'd2;
	localparam logic [7:0]  NEG_TYPE_FAILURE     = 8'd3;
	localparam logic [31:0] NEG_FAIL_UNSUPPORTED = 32'd5;

endpackage

/* src/tpkt_cotp_rdp_negotiation_parser.sv */
// ----------------------------------------------------------------------------
// tpkt_cotp_rdp_negotiation_parser
// Parses an RDP connection reply byte by byte and reports the NLA verdict or a parse error.
// ----------------------------------------------------------------------------
// Each event is registered in the event buffer and leaves it in arrival order.
// Throughput: one byte per cycle; the two-word event buffer lets input run on
// while an event waits, and input stalls only when both buffer words are full.
// Reset clears all layer state and empties the event buffer.
module tpkt_cotp_rdp_negotiation_parser import rdpneg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	evt_t       evt;
	logic       accept, push, pop;
	logic       head_q;
	logic [1:0] cnt_q;
	logic       tail;
	out_word_t  buf_q [2];

	assign in_ready = (cnt_q != 2'd2);
	assign accept   = in_valid & in_ready;
	assign push     = accept & evt.valid;
	assign out_valid = (cnt_q != 2'd0);
	assign pop      = out_valid & out_ready;
	assign tail     = head_q ^ cnt_q[0];
	assign out_data = buf_q[head_q];

	rdpneg_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.in_data (in_data),
		.evt     (evt)
	);

	always_ff @(posedge clk) begin
		if (push)
			buf_q[tail] <= evt.word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (pop)
				head_q <= ~head_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("event buffer count out of range");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.word.event_code[2]) |->
		(evt.word.negotiation_result == 32'd0 && evt.word.negotiation_flags == 8'd0))
		else $error("error event carries negotiation data");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("event lost on push");

	a_push_data: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cnt_q == 2'd0) |=> (out_data == $past(evt.word)))
		else $error("event buffer shows wrong word");

endmodule

/* src/rdpneg_core.sv */
// ----------------------------------------------------------------------------
// rdpneg_core
// Layer state of the reply parser and the per-byte update of all three layers.
// ----------------------------------------------------------------------------
module rdpneg_core import rdpneg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_word_t in_data,
	output evt_t     evt
);

	tp_state_t   tp_q, c_tp, n_tp;
	logic [15:0] trem_q, c_trem, n_trem;
	co_state_t   co_q, c_co, n_co;
	logic [7:0]  crem_q, c_crem, n_crem;
	logic [7:0]  ckind_q, c_ckind, n_ckind;
	ng_state_t   ng_q, c_ng, n_ng;
	logic [7:0]  nkind_q, c_nkind, n_nkind;
	logic [7:0]  flags_q, c_flags, n_flags;
	logic [7:0]  nrem_q, c_nrem, n_nrem;
	logic [31:0] word_q, c_word, n_word;

	logic [7:0]  b;
	logic [15:0] len;
	logic [31:0] w;

	assign b = in_data.data_byte;

	always_comb begin
		// A stream start clears every layer before the byte is parsed.
		if (in_data.starts_stream) begin
			c_tp    = TP_VERSION;
			c_trem  = '0;
			c_co    = CO_LENGTH;
			c_crem  = '0;
			c_ckind = '0;
			c_ng    = NG_TYPE;
			c_nkind = '0;
			c_flags = '0;
			c_nrem  = '0;
			c_word  = '0;
		end else begin
			c_tp    = tp_q;
			c_trem  = trem_q;
			c_co    = co_q;
			c_crem  = crem_q;
			c_ckind = ckind_q;
			c_ng    = ng_q;
			c_nkind = nkind_q;
			c_flags = flags_q;
			c_nrem  = nrem_q;
			c_word  = word_q;
		end

		n_tp    = c_tp;
		n_trem  = c_trem;
		n_co    = c_co;
		n_crem  = c_crem;
		n_ckind = c_ckind;
		n_ng    = c_ng;
		n_nkind = c_nkind;
		n_flags = c_flags;
		n_nrem  = c_nrem;
		n_word  = c_word;
		evt     = '0;
		len     = c_trem | {8'h00, b};
		w       = {b, c_word[31:8]};

		unique case (c_tp)
			TP_VERSION: begin
				if (b != TPKT_VERSION) begin
					n_tp                 = TP_DEAD;
					evt.valid            = 1'b1;
					evt.word.event_code  = EV_NOT_TPKT;
				end else begin
					n_trem = '0;
					n_co   = CO_LENGTH;
					n_tp   = TP_RESERVED;
				end
			end
			TP_RESERVED: n_tp = TP_LEN_HI;
			TP_LEN_HI: begin
				n_trem = {b, 8'h00};
				n_tp   = TP_LEN_LO;
			end
			TP_LEN_LO: begin
				if (len < TPKT_HDR_LEN) begin
					n_trem              = len;
					n_tp                = TP_DEAD;
					evt.valid           = 1'b1;
					evt.word.event_code = EV_NOT_TPKT;
				end else begin
					n_trem = len - TPKT_HDR_LEN;
					n_tp   = (len != TPKT_HDR_LEN) ? TP_CONTENT : TP_VERSION;
				end
			end
			TP_CONTENT: begin
				n_trem = c_trem - 16'd1;
				if (c_trem == 16'd1)
					n_tp = TP_VERSION;
				unique case (c_co)
					CO_LENGTH: begin
						if (b < COTP_MIN_LEN) begin
							n_co                = CO_DONE;
							evt.valid           = 1'b1;
							evt.word.event_code = EV_BAD_COTP_LEN;
						end else begin
							n_crem = b - COTP_MIN_LEN;
							n_co   = CO_TYPE;
						end
					end
					CO_TYPE: begin
						n_ckind = b;
						n_co    = CO_REF0;
					end
					CO_REF0: n_co = CO_REF1;
					CO_REF1: n_co = CO_REF2;
					CO_REF2: n_co = CO_REF3;
					CO_REF3: n_co = CO_CLASS;
					CO_CLASS: begin
						n_ng = NG_TYPE;
						n_co = (c_crem != 8'd0) ? CO_CONTENT : CO_DONE;
					end
					CO_CONTENT: begin
						if (c_ckind != COTP_CC_PDU) begin
							n_co                = CO_DONE;
							evt.valid           = 1'b1;
							evt.word.event_code = EV_UNKNOWN_COTP;
						end else begin
							n_crem = c_crem - 8'd1;
							if (c_crem == 8'd1)
								n_co = CO_DONE;
							unique case (c_ng)
								NG_TYPE: begin
									n_nkind = b;
									n_ng    = NG_FLAGS;
								end
								NG_FLAGS: begin
									n_flags = b;
									n_ng    = NG_LENGTH;
								end
								NG_LENGTH: begin
									if (b < NEG_MIN_LEN) begin
										n_ng                = NG_DONE;
										evt.valid           = 1'b1;
										evt.word.event_code = EV_BAD_NEG_LEN;
									end else begin
										n_nrem = b - NEG_MIN_LEN;
										n_ng   = NG_RESERVED;
									end
								end
								NG_RESERVED: begin
									if (c_nkind == NEG_TYPE_RESPONSE ||
									    c_nkind == NEG_TYPE_FAILURE) begin
										n_word = '0;
										n_ng   = NG_RESULT0;
									end else begin
										n_ng = NG_DONE;
									end
								end
								NG_RESULT0, NG_RESULT1, NG_RESULT2, NG_RESULT3: begin
									if (c_nrem == 8'd0) begin
										n_ng = NG_DONE;
									end else begin
										n_nrem = c_nrem - 8'd1;
										n_word = w;
										unique case (c_ng)
											NG_RESULT0: n_ng = NG_RESULT1;
											NG_RESULT1: n_ng = NG_RESULT2;
											NG_RESULT2: n_ng = NG_RESULT3;
											default: begin
												// Last result byte: give the verdict.
												n_ng      = NG_DONE;
												evt.valid = 1'b1;
												evt.word.negotiation_result = w;
												evt.word.negotiation_flags  = c_flags;
												if (c_nkind == NEG_TYPE_RESPONSE)
													evt.word.event_code = w[1] ?
														EV_NLA_SUPPORTED : EV_NLA_UNUSED;
												else
													evt.word.event_code =
														(w == NEG_FAIL_UNSUPPORTED) ?
														EV_NLA_UNSUPPORTED : EV_FAILURE;
											end
										endcase
									end
								end
								NG_DONE: ;
								default: n_ng = NG_DONE;
							endcase
						end
					end
					CO_DONE: ;
					default: n_co = CO_DONE;
				endcase
			end
			TP_DEAD: ;
			default: n_tp = TP_DEAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q    <= TP_VERSION;
			trem_q  <= '0;
			co_q    <= CO_LENGTH;
			crem_q  <= '0;
			ckind_q <= '0;
			ng_q    <= NG_TYPE;
			nkind_q <= '0;
			flags_q <= '0;
			nrem_q  <= '0;
			word_q  <= '0;
		end else if (step) begin
			tp_q    <= n_tp;
			trem_q  <= n_trem;
			co_q    <= n_co;
			crem_q  <= n_crem;
			ckind_q <= n_ckind;
			ng_q    <= n_ng;
			nkind_q <= n_nkind;
			flags_q <= n_flags;
			nrem_q  <= n_nrem;
			word_q  <= n_word;
		end
	end

endmodule
